>>> hw/rtl/sce_pkg.sv
// Package for the softmax cross-entropy unit: widths, controller states,
// command and status structs, and the 2^(-i/16) table. No dependencies.
package sce_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int LOGIT_W     = 16;
    localparam int TARGET_W    = 16;
    localparam int PROB_W      = 16;
    localparam int GRAD_W      = 17;
    localparam int BATCH_W     = 11;
    localparam int SUM_W       = 24;
    localparam int EXP_W       = 17;
    localparam int RECIP_W     = 17;
    localparam int DIVQ_W      = 33;
    localparam int DIVR_W      = SUM_W + 1;
    localparam int DIVC_W      = 6;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_X1, S_X2, S_X3, S_ACC, S_RECIP, S_RWAIT,
        S_MUL, S_GRAD, S_GWAIT, S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic x1;
        logic x2;
        logic x3;
        logic acc;
        logic recip_start;
        logic recip_load;
        logic mul;
        logic grad_start;
        logic out_load;
        logic row_done;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic idx_last;
    } t_dp_stat;

    function automatic logic [16:0] pow2_neg(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/sce_if.sv
// Stream and configuration channel interfaces of the softmax cross-entropy unit.
// Depends on sce_pkg.
interface sce_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [sce_pkg::LOGIT_W-1:0] logit;
    logic [sce_pkg::TARGET_W-1:0]   target;
    logic                           row_end;
    modport source (output valid, logit, target, row_end, input ready);
    modport sink   (input valid, logit, target, row_end, output ready);
endinterface

interface sce_out_if;
    logic                              valid;
    logic                              ready;
    logic [sce_pkg::PROB_W-1:0]        probability;
    logic signed [sce_pkg::GRAD_W-1:0] gradient;
    logic                              last;
    modport source (output valid, probability, gradient, last, input ready);
    modport sink   (input valid, probability, gradient, last, output ready);
endinterface

interface sce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sce_pkg::BATCH_W-1:0] batch_size;
    modport source (output valid, batch_size, input ready);
    modport sink   (input valid, batch_size, output ready);
endinterface

>>> hw/rtl/softmax_cross_entropy_unit.sv
// Softmax cross-entropy unit: one class per input transaction; on row end,
// one probability/gradient result per stored class (up to 16).
// Flow: a first pass over the row does exp and sum, then the reciprocal divider runs;
// a second pass gives each result (exp, multiply, 17-step gradient divider) plus stall.
// Throughput: one row at a time; loading accepts one class per cycle.
// Reset (synchronous, active low) clears count, sum and max and sets batch size to one.
module softmax_cross_entropy_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sce_in_if.sink       i_in_ch,
    sce_out_if.source    o_out_ch,
    sce_cfg_if.sink      i_cfg_ch
);
    import sce_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg_ch.ready = 1'b1;

    sce_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_ch.valid),
        .i_in_row_end (i_in_ch.row_end),
        .i_out_ready  (o_out_ch.ready),
        .i_stat       (stat),
        .o_in_ready   (i_in_ch.ready),
        .o_out_valid  (o_out_ch.valid),
        .o_cmd        (cmd)
    );

    sce_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_logit       (i_in_ch.logit),
        .i_target      (i_in_ch.target),
        .i_cfg_we      (i_cfg_ch.valid),
        .i_cfg_batch   (i_cfg_ch.batch_size),
        .o_probability (o_out_ch.probability),
        .o_gradient    (o_out_ch.gradient),
        .o_last        (o_out_ch.last)
    );
endmodule

>>> hw/rtl/sce_div.sv
// Restoring divider, one quotient bit per cycle, for the reciprocal and gradient.
// Depends on sce_pkg.
module sce_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sce_pkg::DIVQ_W-1:0]    i_dividend,
    input  logic [sce_pkg::SUM_W-1:0]     i_divisor,
    input  logic [sce_pkg::DIVC_W-1:0]    i_steps,
    output logic                          o_busy,
    output logic [sce_pkg::DIVQ_W-1:0]    o_quotient
);
    import sce_pkg::*;

    logic [DIVR_W-1:0] r_rem, n_rem, rem_sh;
    logic [DIVQ_W-1:0] r_quo, n_quo;
    logic [DIVC_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_dsr;
    logic              r_busy;

    always_comb begin
        rem_sh = {r_rem[DIVR_W-2:0], r_quo[DIVQ_W-1]};
        n_quo  = {r_quo[DIVQ_W-2:0], 1'b0};
        n_rem  = rem_sh;
        if (rem_sh >= {1'b0, r_dsr}) begin
            n_rem    = rem_sh - {1'b0, r_dsr};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIVC_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

>>> hw/rtl/sce_ctrl.sv
// Controller state machine of the softmax cross-entropy unit.
// Depends on sce_pkg; drives the datapath through t_dp_cmd.
module sce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_row_end,
    input  logic              i_out_ready,
    input  sce_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output sce_pkg::t_dp_cmd  o_cmd
);
    import sce_pkg::*;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_row_end) begin
                        o_cmd.idx_clr = 1'b1;
                        n_pass        = 1'b0;
                        n_state       = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_X1;
            end
            S_X1: begin
                o_cmd.x1 = 1'b1;
                n_state  = S_X2;
            end
            S_X2: begin
                o_cmd.x2 = 1'b1;
                n_state  = S_X3;
            end
            S_X3: begin
                o_cmd.x3 = 1'b1;
                n_state  = r_pass ? S_MUL : S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_RECIP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RECIP: begin
                o_cmd.recip_start = 1'b1;
                n_state           = S_RWAIT;
            end
            S_RWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.recip_load = 1'b1;
                    n_pass           = 1'b1;
                    n_state          = S_RD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_GRAD;
            end
            S_GRAD: begin
                o_cmd.grad_start = 1'b1;
                n_state          = S_GWAIT;
            end
            S_GWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.idx_last) begin
                        o_cmd.row_done = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_out_ready) |=> r_state == S_EMIT)
        else $error("result dropped while stalled");
    a_busy_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_busy |-> (r_state == S_RWAIT || r_state == S_GWAIT))
        else $error("divider busy outside a wait state");
    a_sum_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && i_stat.idx_last) |=> r_state == S_RECIP)
        else $error("reciprocal not started after last sum term");
endmodule

>>> hw/rtl/sce_dp.sv
// Datapath of the softmax cross-entropy unit: row stores, exp evaluation,
// sum, reciprocal and gradient. Depends on sce_pkg and sce_div.
module sce_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sce_pkg::t_dp_cmd                    i_cmd,
    output sce_pkg::t_dp_stat                   o_stat,
    input  logic signed [sce_pkg::LOGIT_W-1:0]  i_logit,
    input  logic [sce_pkg::TARGET_W-1:0]        i_target,
    input  logic                                i_cfg_we,
    input  logic [sce_pkg::BATCH_W-1:0]         i_cfg_batch,
    output logic [sce_pkg::PROB_W-1:0]          o_probability,
    output logic signed [sce_pkg::GRAD_W-1:0]   o_gradient,
    output logic                                o_last
);
    import sce_pkg::*;

    logic [LOGIT_W-1:0]  logit_mem  [MAX_CLASSES];
    logic [TARGET_W-1:0] target_mem [MAX_CLASSES];

    logic signed [LOGIT_W-1:0] r_row_max, r_logit_q;
    logic [TARGET_W-1:0]       r_target_q;
    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          r_idx;
    logic [BATCH_W-1:0]        r_batch;
    logic [SUM_W-1:0]          r_sum;
    logic [24:0]               r_u;
    logic [16:0]               r_m;
    logic [8:0]                r_k;
    logic [EXP_W-1:0]          r_e;
    logic [RECIP_W-1:0]        r_recip;
    logic [PROB_W-1:0]         r_p;
    logic                      r_neg;
    logic [PROB_W-1:0]         r_prob_o;
    logic signed [GRAD_W-1:0]  r_grad_o;
    logic                      r_last_o;

    logic signed [LOGIT_W:0]   diff;
    logic [32:0]               uprod;
    logic [3:0]                ti;
    logic [11:0]               tr;
    logic [16:0]               t_a, t_b;
    logic [23:0]               iprod;
    logic [17:0]               rnd;
    logic [17:0]               shifted;
    logic [EXP_W-1:0]          e_val;
    logic [33:0]               pprod;
    logic signed [GRAD_W-1:0]  dval;
    logic [PROB_W-1:0]         dmag;
    logic                      idx_last;
    logic                      div_start, div_busy;
    logic [DIVQ_W-1:0]         div_dividend, div_q;
    logic [SUM_W-1:0]          div_divisor;
    logic [DIVC_W-1:0]         div_steps;
    logic [BATCH_W-1:0]        b_eff;

    assign idx_last = r_idx == IDX_W'(r_count - 1'b1);
    assign o_stat   = '{div_busy: div_busy, idx_last: idx_last};
    assign b_eff    = (r_batch == '0) ? BATCH_W'(1) : r_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch <= BATCH_W'(1);
        end else if (i_cfg_we) begin
            r_batch <= i_cfg_batch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_row_max <= '0;
        end else if (i_cmd.load && r_count < CNT_W'(MAX_CLASSES)) begin
            if (r_count == '0 || i_logit > r_row_max) begin
                r_row_max <= i_logit;
            end
            r_count <= r_count + 1'b1;
        end else if (i_cmd.row_done) begin
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CNT_W'(MAX_CLASSES)) begin
            logit_mem[r_count[IDX_W-1:0]]  <= i_logit;
            target_mem[r_count[IDX_W-1:0]] <= i_target;
        end
        if (i_cmd.rd) begin
            r_logit_q  <= logit_mem[r_idx];
            r_target_q <= target_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_comb begin
        diff    = {r_row_max[LOGIT_W-1], r_row_max} - {r_logit_q[LOGIT_W-1], r_logit_q};
        uprod   = 33'(diff[15:0]) * 33'(LOG2E_Q16) + 33'd128;
        ti      = r_u[15:12];
        tr      = r_u[11:0];
        t_a     = pow2_neg({1'b0, ti});
        t_b     = pow2_neg(5'({1'b0, ti}) + 5'd1);
        iprod   = 24'(t_a - t_b) * 24'(tr) + 24'd2048;
        rnd     = 18'(1) << (r_k[4:0] - 5'd1);
        shifted = (18'(r_m) + rnd) >> r_k[4:0];
        if (r_k == '0) begin
            e_val = r_m;
        end else if (r_k > 9'd16) begin
            e_val = '0;
        end else begin
            e_val = shifted[EXP_W-1:0];
        end
        pprod = 34'(r_e) * 34'(r_recip) + 34'd32768;
        dval  = $signed({1'b0, r_p}) - $signed({1'b0, r_target_q});
        dmag  = dval[GRAD_W-1] ? PROB_W'(-dval) : dval[PROB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x1) begin
            r_u <= uprod[32:8];
        end
        if (i_cmd.x2) begin
            r_m <= t_a - 17'(iprod[23:12]);
            r_k <= r_u[24:16];
        end
        if (i_cmd.x3) begin
            r_e <= e_val;
        end
        if (i_cmd.mul) begin
            r_p <= (pprod[33:16] > 18'd65535) ? 16'hFFFF : pprod[31:16];
        end
        if (i_cmd.grad_start) begin
            r_neg <= dval[GRAD_W-1];
        end
        if (i_cmd.recip_load) begin
            r_recip <= (r_sum == '0) ? '0 : div_q[RECIP_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_prob_o <= r_p;
            r_grad_o <= r_neg ? -$signed({1'b0, div_q[PROB_W-1:0]})
                              : $signed({1'b0, div_q[PROB_W-1:0]});
            r_last_o <= idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.load) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SUM_W'(r_e);
        end
    end

    always_comb begin
        div_start = i_cmd.recip_start | i_cmd.grad_start;
        if (i_cmd.recip_start) begin
            div_dividend = DIVQ_W'(1) << 32;
            div_divisor  = r_sum;
            div_steps    = DIVC_W'(DIVQ_W);
        end else begin
            div_dividend = DIVQ_W'(dmag) << 16;
            div_divisor  = SUM_W'(b_eff);
            div_steps    = DIVC_W'(GRAD_W);
        end
    end

    sce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign o_probability = r_prob_o;
    assign o_gradient    = r_grad_o;
    assign o_last        = r_last_o;
endmodule
